// ----- rtl/ssf_pkg.sv -----
`default_nettype none

package ssf_pkg;

  // Grid and supersampling geometry.
  localparam int GRID_SIZE       = 64;
  localparam int SUBSAMPLE_STEPS = 3;
  localparam int PTS             = SUBSAMPLE_STEPS + 1;
  localparam int PAIRS           = PTS * PTS;
  localparam int TOTAL           = PTS * PTS * PTS;

  // Field widths.
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 18;
  localparam int CTR_W      = 16;
  localparam int RAD_W      = 34;
  localparam int FRAC_W     = 8;
  localparam int CNT_W      = $clog2(TOTAL + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 32;

  // Distance arithmetic widths.
  localparam int MAX_POS = ((1 << IDX_W) - 1) * SUBSAMPLE_STEPS + SUBSAMPLE_STEPS;
  localparam int POS_W   = $clog2(MAX_POS + 1) + FRAC_W;
  localparam int ABS_W   = (POS_W > CTR_W) ? POS_W : CTR_W;
  localparam int DIF_W   = ABS_W + 1;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int PAIR_W  = SQ_W + 1;
  localparam int TRI_W   = SQ_W + 2;
  localparam int CMP_W   = (TRI_W > RAD_W) ? TRI_W : RAD_W;

  // Blend arithmetic widths: signed value times signed (count + sign) factor.
  localparam int PROD_W = VAL_W + CNT_W + 1;
  localparam int U_W    = PROD_W - 1;
  localparam int DIV_SH = U_W;
  localparam logic [DIV_SH-1:0] DIV_MUL = DIV_SH'((64'd1 << DIV_SH) / TOTAL);

  // Pipeline depth.
  localparam int NSTAGE = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILL   = 3'd5;

  localparam logic signed [VAL_W-1:0] FILL_RESET = 18'sd65536;
  localparam logic signed [VAL_W-1:0] VAL_MAX    = 18'sd131071;
  localparam logic signed [VAL_W-1:0] VAL_MIN    = -18'sd131072;

  typedef logic [ABS_W-1:0] abs_t;
  typedef logic [SQ_W-1:0]  sq_t;

  // Per-stage load enables, bit 0 is the first stage.
  typedef struct packed {
    logic [NSTAGE-1:0] ld;
  } pipe_ctrl_t;

  // Sideband that rides along with each request.
  typedef struct packed {
    logic [VAL_W-1:0] old;
    logic             inr;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/ssf_axis.sv -----
`default_nettype none

module ssf_axis (
  input  wire logic                     clk,
  input  wire ssf_pkg::pipe_ctrl_t      ctrl,
  input  wire logic [ssf_pkg::IDX_W-1:0] idx,
  input  wire logic [ssf_pkg::CTR_W-1:0] ctr,
  output ssf_pkg::sq_t                  sq_o [ssf_pkg::PTS]
);

  logic [ssf_pkg::POS_W-1:0] base   [ssf_pkg::PTS];
  logic [ssf_pkg::POS_W-1:0] pos    [ssf_pkg::PTS];
  logic [ssf_pkg::DIF_W-1:0] ea     [ssf_pkg::PTS];
  logic [ssf_pkg::DIF_W-1:0] eb     [ssf_pkg::PTS];
  logic [ssf_pkg::DIF_W-1:0] dpos   [ssf_pkg::PTS];
  logic [ssf_pkg::DIF_W-1:0] dneg   [ssf_pkg::PTS];
  ssf_pkg::abs_t             abs_nxt [ssf_pkg::PTS];
  ssf_pkg::abs_t             abs_r   [ssf_pkg::PTS];
  ssf_pkg::sq_t              sq_nxt  [ssf_pkg::PTS];
  ssf_pkg::sq_t              sq_r    [ssf_pkg::PTS];

  // Sample position is (STEPS*idx + s) with the fraction bits appended.
  always_comb begin
    for (int s = 0; s < ssf_pkg::PTS; s++) begin
      base[s] = ssf_pkg::POS_W'(idx) * ssf_pkg::POS_W'(ssf_pkg::SUBSAMPLE_STEPS)
              + ssf_pkg::POS_W'(s);
      pos[s]  = base[s] << ssf_pkg::FRAC_W;
      ea[s]   = ssf_pkg::DIF_W'(pos[s]);
      eb[s]   = ssf_pkg::DIF_W'(ctr);
      dpos[s] = ea[s] - eb[s];
      dneg[s] = eb[s] - ea[s];
      abs_nxt[s] = (ea[s] < eb[s]) ? dneg[s][ssf_pkg::ABS_W-1:0]
                                   : dpos[s][ssf_pkg::ABS_W-1:0];
      sq_nxt[s]  = ssf_pkg::SQ_W'(abs_r[s]) * ssf_pkg::SQ_W'(abs_r[s]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[0]) begin
      abs_r <= abs_nxt;
    end
    if (ctrl.ld[1]) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq_o = sq_r;

endmodule

`default_nettype wire

// ----- rtl/ssf_cover.sv -----
`default_nettype none

module ssf_cover (
  input  wire logic                       clk,
  input  wire ssf_pkg::pipe_ctrl_t        ctrl,
  input  wire ssf_pkg::sq_t               dx [ssf_pkg::PTS],
  input  wire ssf_pkg::sq_t               dy [ssf_pkg::PTS],
  input  wire ssf_pkg::sq_t               dz [ssf_pkg::PTS],
  input  wire logic [ssf_pkg::RAD_W-1:0]  radius,
  input  wire logic                       cyl,
  input  wire logic                       inr,
  output logic [ssf_pkg::CNT_W-1:0]       k_o
);

  logic [ssf_pkg::PAIR_W-1:0] pair_nxt [ssf_pkg::PAIRS];
  logic [ssf_pkg::PAIR_W-1:0] pair_r   [ssf_pkg::PAIRS];
  ssf_pkg::sq_t               dz_r     [ssf_pkg::PTS];
  logic [ssf_pkg::TOTAL-1:0]  hit_nxt;
  logic [ssf_pkg::TOTAL-1:0]  hit_r;
  logic [ssf_pkg::CMP_W-1:0]  rad;
  logic [ssf_pkg::CNT_W-1:0]  cnt;
  logic [ssf_pkg::CNT_W-1:0]  kc;
  logic [ssf_pkg::CNT_W-1:0]  k_nxt;
  logic [ssf_pkg::CNT_W-1:0]  k_r;

  always_comb begin
    for (int a = 0; a < ssf_pkg::PTS; a++) begin
      for (int b = 0; b < ssf_pkg::PTS; b++) begin
        pair_nxt[a*ssf_pkg::PTS + b] = ssf_pkg::PAIR_W'(dx[a]) + ssf_pkg::PAIR_W'(dy[b]);
      end
    end
  end

  // The cylinder uses only the low PAIRS hit bits; the sphere uses all of them.
  always_comb begin
    rad     = ssf_pkg::CMP_W'(radius);
    hit_nxt = '0;
    for (int p = 0; p < ssf_pkg::PAIRS; p++) begin
      if (cyl) begin
        hit_nxt[p] = ssf_pkg::CMP_W'(pair_r[p]) <= rad;
      end else begin
        for (int c = 0; c < ssf_pkg::PTS; c++) begin
          hit_nxt[p*ssf_pkg::PTS + c] =
            (ssf_pkg::CMP_W'(pair_r[p]) + ssf_pkg::CMP_W'(dz_r[c])) <= rad;
        end
      end
    end
  end

  always_comb begin
    cnt   = ssf_pkg::CNT_W'($countones(hit_r));
    kc    = cyl ? ssf_pkg::CNT_W'(int'(cnt) * ssf_pkg::PTS) : cnt;
    k_nxt = inr ? kc : '0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[2]) begin
      pair_r <= pair_nxt;
      dz_r   <= dz;
    end
    if (ctrl.ld[3]) begin
      hit_r <= hit_nxt;
    end
    if (ctrl.ld[4]) begin
      k_r <= k_nxt;
    end
  end

  assign k_o = k_r;

endmodule

`default_nettype wire

// ----- rtl/ssf_blend.sv -----
`default_nettype none

module ssf_blend (
  input  wire logic                               clk,
  input  wire ssf_pkg::pipe_ctrl_t                ctrl,
  input  wire logic [ssf_pkg::CNT_W-1:0]          k_in,
  input  wire logic signed [ssf_pkg::VAL_W-1:0]   old_mul,
  input  wire logic signed [ssf_pkg::VAL_W-1:0]   old_out,
  input  wire logic signed [ssf_pkg::VAL_W-1:0]   fill,
  output logic signed [ssf_pkg::VAL_W-1:0]        new_value,
  output logic [ssf_pkg::CNT_W-1:0]               coverage_count,
  output logic                                    touched
);

  localparam int MUL_W = ssf_pkg::U_W + ssf_pkg::DIV_SH;

  logic                                 pos_fill;
  logic signed [ssf_pkg::VAL_W-1:0]     sel;
  logic [ssf_pkg::CNT_W-1:0]            fac;
  logic signed [ssf_pkg::CNT_W:0]       fac_s;
  logic signed [ssf_pkg::PROD_W-1:0]    prod_nxt;
  logic signed [ssf_pkg::PROD_W-1:0]    prod_r;
  logic [ssf_pkg::CNT_W-1:0]            k6_r;

  logic                                 neg;
  logic [ssf_pkg::PROD_W-1:0]           mag;
  logic [ssf_pkg::U_W-1:0]              u_nxt;
  logic [MUL_W-1:0]                     mul;
  logic [ssf_pkg::U_W-1:0]              q0_nxt;
  logic [ssf_pkg::U_W-1:0]              u_r;
  logic [ssf_pkg::U_W-1:0]              q0_r;
  logic                                 neg_r;
  logic [ssf_pkg::CNT_W-1:0]            k7_r;

  logic [ssf_pkg::U_W-1:0]              qt;
  logic [ssf_pkg::U_W-1:0]              rem;
  logic [ssf_pkg::U_W-1:0]              q;
  logic signed [ssf_pkg::PROD_W-1:0]    qs;
  logic signed [ssf_pkg::VAL_W-1:0]     sat;
  logic signed [ssf_pkg::VAL_W-1:0]     new_nxt;
  logic signed [ssf_pkg::VAL_W-1:0]     new_r;
  logic [ssf_pkg::CNT_W-1:0]            cnt_r;
  logic                                 touched_r;

  // Paint scales the fill by the count, carving scales the old value by the rest.
  always_comb begin
    pos_fill = fill > $signed(ssf_pkg::VAL_W'(0));
    sel      = pos_fill ? fill : old_mul;
    fac      = pos_fill ? k_in : ssf_pkg::CNT_W'(ssf_pkg::TOTAL) - k_in;
    fac_s    = $signed({1'b0, fac});
    prod_nxt = ssf_pkg::PROD_W'(sel) * ssf_pkg::PROD_W'(fac_s);
  end

  // Floor division works on the one's complement for negative products, so the
  // quotient of the magnitude can be taken with a reciprocal multiply.
  always_comb begin
    neg    = prod_r[ssf_pkg::PROD_W-1];
    mag    = neg ? ~prod_r : prod_r;
    u_nxt  = mag[ssf_pkg::U_W-1:0];
    mul    = MUL_W'(u_nxt) * MUL_W'(ssf_pkg::DIV_MUL);
    q0_nxt = mul[MUL_W-1:ssf_pkg::DIV_SH];
  end

  // The reciprocal estimate is at most one low; one compare fixes it.
  always_comb begin
    qt  = ssf_pkg::U_W'(q0_r * ssf_pkg::U_W'(ssf_pkg::TOTAL));
    rem = u_r - qt;
    q   = (rem >= ssf_pkg::U_W'(ssf_pkg::TOTAL)) ? q0_r + ssf_pkg::U_W'(1) : q0_r;
    qs  = neg_r ? $signed(~{1'b0, q}) : $signed({1'b0, q});
    if (qs > ssf_pkg::PROD_W'(ssf_pkg::VAL_MAX)) begin
      sat = ssf_pkg::VAL_MAX;
    end else if (qs < ssf_pkg::PROD_W'(ssf_pkg::VAL_MIN)) begin
      sat = ssf_pkg::VAL_MIN;
    end else begin
      sat = qs[ssf_pkg::VAL_W-1:0];
    end
    new_nxt = (k7_r == '0) ? old_out : sat;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[5]) begin
      prod_r <= prod_nxt;
      k6_r   <= k_in;
    end
    if (ctrl.ld[6]) begin
      u_r   <= u_nxt;
      q0_r  <= q0_nxt;
      neg_r <= neg;
      k7_r  <= k6_r;
    end
    if (ctrl.ld[7]) begin
      new_r     <= new_nxt;
      cnt_r     <= k7_r;
      touched_r <= k7_r != '0;
    end
  end

  assign new_value      = new_r;
  assign coverage_count = cnt_r;
  assign touched        = touched_r;

endmodule

`default_nettype wire

// ----- rtl/supersampled_sphere_cylinder_fill_core.sv -----
`default_nettype none

// Anti-aliased sphere / cylinder paint for a stream of voxels.
//
// Input channel (in_*): one request per voxel, carrying its x, y, z indices
// and the current field value. Output channel (out_*): one request per input,
// in the same order, with the new field value, the count of covered
// subsamples and a touched flag. Configuration channel (cfg_*): writes the
// shape select, the tripled centre, the scaled squared radius and the fill
// value; it is always ready and should only be written while no voxel is in
// flight.
//
// The datapath is an eight-stage pipeline: per-axis distances, squares, pair
// sums, subsample compares, coverage count, blend multiply, reciprocal
// divide and the saturating output register. An accepted voxel passes
// through every stage register in order to the output, and one voxel can
// be taken every cycle while the receiver does not stall. The subsample
// compare stage and the reciprocal multiply set the cycle time.
//
// Reset clears all valid bits and loads the register reset values. When the
// receiver stalls, each stage holds its voxel while empty stages ahead of it
// keep filling, so input requests are still taken until the pipeline is full.

module supersampled_sphere_cylinder_fill_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input: voxel_x, voxel_y, voxel_z, old_value, then zero padding.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [ssf_pkg::IN_W-1:0]        in_tdata,
  // Output: new_value, coverage_count, touched, then zero padding.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [ssf_pkg::OUT_W-1:0]            out_tdata,
  // Configuration write channel.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ssf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ssf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int NS = ssf_pkg::NSTAGE;

  // Configuration registers.
  logic                                shape_r;
  logic [ssf_pkg::CTR_W-1:0]           cx_r;
  logic [ssf_pkg::CTR_W-1:0]           cy_r;
  logic [ssf_pkg::CTR_W-1:0]           cz_r;
  logic [ssf_pkg::RAD_W-1:0]           rad_r;
  logic signed [ssf_pkg::VAL_W-1:0]    fill_r;

  // Pipeline control.
  logic [NS-1:0]                       valid_r;
  logic [NS-1:0]                       valid_nxt;
  logic [NS-1:0]                       adv;
  ssf_pkg::pipe_ctrl_t                 ctrl;
  ssf_pkg::side_t                      side_r [NS-1];
  ssf_pkg::side_t                      side_in;

  // Unpacked input fields.
  logic [ssf_pkg::IDX_W-1:0]           in_x;
  logic [ssf_pkg::IDX_W-1:0]           in_y;
  logic [ssf_pkg::IDX_W-1:0]           in_z;
  logic [ssf_pkg::VAL_W-1:0]           in_old;

  ssf_pkg::sq_t                        dx [ssf_pkg::PTS];
  ssf_pkg::sq_t                        dy [ssf_pkg::PTS];
  ssf_pkg::sq_t                        dz [ssf_pkg::PTS];
  logic [ssf_pkg::CNT_W-1:0]           k;
  logic signed [ssf_pkg::VAL_W-1:0]    new_value;
  logic [ssf_pkg::CNT_W-1:0]           coverage_count;
  logic                                touched;

  assign in_x   = in_tdata[ssf_pkg::IDX_W-1:0];
  assign in_y   = in_tdata[2*ssf_pkg::IDX_W-1:ssf_pkg::IDX_W];
  assign in_z   = in_tdata[3*ssf_pkg::IDX_W-1:2*ssf_pkg::IDX_W];
  assign in_old = in_tdata[3*ssf_pkg::IDX_W+ssf_pkg::VAL_W-1:3*ssf_pkg::IDX_W];

  // Indices at or beyond the grid size are outside every shape.
  always_comb begin
    side_in.old = in_old;
    side_in.inr = (int'(in_x) < ssf_pkg::GRID_SIZE) && (int'(in_y) < ssf_pkg::GRID_SIZE)
               && (int'(in_z) < ssf_pkg::GRID_SIZE);
  end

  // A stage moves when it is empty or the stage after it moves; the output
  // stage moves when it is empty or the receiver takes its result.
  always_comb begin
    adv[NS-1] = !valid_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !valid_r[i] || adv[i+1];
    end
    for (int i = 0; i < NS; i++) begin
      if (adv[i]) begin
        valid_nxt[i] = (i == 0) ? in_tvalid : valid_r[(i == 0) ? 0 : i - 1];
      end else begin
        valid_nxt[i] = valid_r[i];
      end
    end
    ctrl.ld = adv;
  end

  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // The sideband follows each voxel stage by stage.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      side_r[0] <= side_in;
    end
    for (int i = 1; i < NS - 1; i++) begin
      if (adv[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Configuration writes; indexes beyond the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= 1'b0;
      cx_r    <= '0;
      cy_r    <= '0;
      cz_r    <= '0;
      rad_r   <= '0;
      fill_r  <= ssf_pkg::FILL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssf_pkg::REG_SHAPE:  shape_r <= cfg_data[0];
        ssf_pkg::REG_CTR_X:  cx_r    <= cfg_data[ssf_pkg::CTR_W-1:0];
        ssf_pkg::REG_CTR_Y:  cy_r    <= cfg_data[ssf_pkg::CTR_W-1:0];
        ssf_pkg::REG_CTR_Z:  cz_r    <= cfg_data[ssf_pkg::CTR_W-1:0];
        ssf_pkg::REG_RADIUS: rad_r   <= cfg_data[ssf_pkg::RAD_W-1:0];
        ssf_pkg::REG_FILL:   fill_r  <= $signed(cfg_data[ssf_pkg::VAL_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Stages one and two: per-axis squared distances of the sample offsets.
  ssf_axis u_axis_x (.clk(clk), .ctrl(ctrl), .idx(in_x), .ctr(cx_r), .sq_o(dx));
  ssf_axis u_axis_y (.clk(clk), .ctrl(ctrl), .idx(in_y), .ctr(cy_r), .sq_o(dy));
  ssf_axis u_axis_z (.clk(clk), .ctrl(ctrl), .idx(in_z), .ctr(cz_r), .sq_o(dz));

  // Stages three to five: distance sums, radius compares and coverage count.
  ssf_cover u_cover (
    .clk    (clk),
    .ctrl   (ctrl),
    .dx     (dx),
    .dy     (dy),
    .dz     (dz),
    .radius (rad_r),
    .cyl    (shape_r),
    .inr    (side_r[3].inr),
    .k_o    (k)
  );

  // Stages six to eight: blend multiply, floor divide, saturation.
  ssf_blend u_blend (
    .clk            (clk),
    .ctrl           (ctrl),
    .k_in           (k),
    .old_mul        ($signed(side_r[4].old)),
    .old_out        ($signed(side_r[6].old)),
    .fill           (fill_r),
    .new_value      (new_value),
    .coverage_count (coverage_count),
    .touched        (touched)
  );

  assign out_tvalid = valid_r[NS-1];
  assign out_tdata  = {
    (ssf_pkg::OUT_W - ssf_pkg::VAL_W - ssf_pkg::CNT_W - 1)'(0),
    touched, coverage_count, new_value
  };

endmodule

`default_nettype wire

// ----- rtl/ssf_checker.sv -----
`default_nettype none

module ssf_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [ssf_pkg::OUT_W-1:0]       out_tdata
);

  localparam int CNT_LO = ssf_pkg::VAL_W;
  localparam int CNT_HI = ssf_pkg::VAL_W + ssf_pkg::CNT_W - 1;
  localparam int TCH    = ssf_pkg::VAL_W + ssf_pkg::CNT_W;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // The touched flag follows the coverage count.
  a_touched: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TCH] == (out_tdata[CNT_HI:CNT_LO] != '0))
    else $error("touched flag disagrees with coverage count");

  // Coverage never exceeds the number of subsamples.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[CNT_HI:CNT_LO] <= ssf_pkg::CNT_W'(ssf_pkg::TOTAL))
    else $error("coverage count out of range");

endmodule

bind supersampled_sphere_cylinder_fill_core ssf_checker u_ssf_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none

module tb;
  import ssf_pkg::*;

  // Floor division by the sample count is an arithmetic shift, since the
  // count of subsamples per voxel is a power of two.
  localparam int TOTAL_LOG = $clog2(TOTAL);
  // One voxel spans this many tripled position units with fraction bits.
  localparam int VOXEL_SPAN = SUBSAMPLE_STEPS << FRAC_W;
  // Register indexes past the end of the register list; writes to them are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int MAX_REPORTS = 30;

  // Laid out like the low bits of out_tdata: new_value lowest, touched highest.
  typedef struct packed {
    logic                    touched;
    logic [CNT_W-1:0]        coverage;
    logic signed [VAL_W-1:0] new_value;
  } painted_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Local copy of the paint registers, updated at each accepted write.
  logic                    cyl_mode;
  logic [CTR_W-1:0]        ctr_x, ctr_y, ctr_z;
  logic [RAD_W-1:0]        rad_sq;
  logic signed [VAL_W-1:0] fill_val;

  painted_t pending_paint[$];

  int idle_pct;
  int stall_pct;
  int reach;
  int unsigned mismatches;
  int unsigned voxels_sent;
  int unsigned voxels_checked;
  int unsigned voxels_touched;
  int unsigned settings_used;

  supersampled_sphere_cylinder_fill_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Squared distance along one axis from one subsample to the centre.
  function automatic longint unsigned axis_dist_sq(input logic [IDX_W-1:0] idx,
                                                   input logic [CTR_W-1:0] centre,
                                                   input int sub);
    longint pos;
    longint d;
    pos = longint'((int'(idx) * SUBSAMPLE_STEPS + sub) << FRAC_W);
    d = pos - longint'(centre);
    if (d < 0) d = -d;
    return d * d;
  endfunction

  // Coverage count and blended value for one voxel under the current settings.
  function automatic painted_t paint_voxel(input logic [IDX_W-1:0] vx,
                                           input logic [IDX_W-1:0] vy,
                                           input logic [IDX_W-1:0] vz,
                                           input logic signed [VAL_W-1:0] old);
    longint unsigned sx[PTS];
    longint unsigned sy[PTS];
    longint unsigned sz[PTS];
    int k;
    longint o;
    longint f;
    longint r;
    painted_t p;
    k = 0;
    for (int s = 0; s < PTS; s++) begin
      sx[s] = axis_dist_sq(vx, ctr_x, s);
      sy[s] = axis_dist_sq(vy, ctr_y, s);
      sz[s] = axis_dist_sq(vz, ctr_z, s);
    end
    for (int a = 0; a < PTS; a++) begin
      for (int b = 0; b < PTS; b++) begin
        if (cyl_mode) begin
          // The cylinder ignores z, so every column of samples counts fully.
          if (sx[a] + sy[b] <= rad_sq) k += PTS;
        end else begin
          for (int c = 0; c < PTS; c++) begin
            if (sx[a] + sy[b] + sz[c] <= rad_sq) k++;
          end
        end
      end
    end
    o = longint'(old);
    f = longint'(fill_val);
    r = o;
    if (k > 0) begin
      if (f > 0) r = (f * k) >>> TOTAL_LOG;
      else r = (o * (TOTAL - k)) >>> TOTAL_LOG;
      if (r > longint'(VAL_MAX)) r = longint'(VAL_MAX);
      if (r < longint'(VAL_MIN)) r = longint'(VAL_MIN);
    end
    p.new_value = r[VAL_W-1:0];
    p.coverage  = CNT_W'(k);
    p.touched   = (k > 0);
    return p;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Receiver side: random stalls at the rate of the current phase.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    painted_t want;
    painted_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[VAL_W+CNT_W:0];
      if (pending_paint.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = pending_paint.pop_front();
        if (got.new_value !== want.new_value)
          flag_mismatch($sformatf("result %0d new_value %0d, predicted %0d",
                                  voxels_checked, got.new_value, want.new_value));
        if (got.coverage !== want.coverage)
          flag_mismatch($sformatf("result %0d coverage %0d, predicted %0d",
                                  voxels_checked, got.coverage, want.coverage));
        if (got.touched !== want.touched)
          flag_mismatch($sformatf("result %0d touched %0b, predicted %0b",
                                  voxels_checked, got.touched, want.touched));
      end
      voxels_checked++;
    end
  end

  // Sends one voxel request; entered and left at a falling edge, valid left high.
  task automatic send_voxel(input logic [IDX_W-1:0] vx, input logic [IDX_W-1:0] vy,
                            input logic [IDX_W-1:0] vz,
                            input logic signed [VAL_W-1:0] old);
    painted_t p;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({old, vz, vy, vx});
    do @(posedge clk); while (!in_tready);
    p = paint_voxel(vx, vy, vz, old);
    pending_paint.push_back(p);
    voxels_sent++;
    if (p.touched) voxels_touched++;
    @(negedge clk);
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic drain_paint();
    in_tvalid <= 1'b0;
    while (pending_paint.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SHAPE:  cyl_mode = data[0];
      REG_CTR_X:  ctr_x    = data[CTR_W-1:0];
      REG_CTR_Y:  ctr_y    = data[CTR_W-1:0];
      REG_CTR_Z:  ctr_z    = data[CTR_W-1:0];
      REG_RADIUS: rad_sq   = data[RAD_W-1:0];
      REG_FILL:   fill_val = data[VAL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Writes all six registers once the pipeline is empty. Unused upper data
  // bits carry random junk so that the register masking is exercised too.
  task automatic set_shape(input logic cyl, input logic [CTR_W-1:0] cx,
                           input logic [CTR_W-1:0] cy, input logic [CTR_W-1:0] cz,
                           input logic [RAD_W-1:0] rad,
                           input logic signed [VAL_W-1:0] fill);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    drain_paint();
    write_reg(REG_SHAPE,  {junk[CFG_DATA_W-1:1], cyl});
    write_reg(REG_CTR_X,  {junk[CFG_DATA_W-1:CTR_W], cx});
    write_reg(REG_CTR_Y,  {junk[CFG_DATA_W-1:CTR_W], cy});
    junk = {$urandom, $urandom};
    write_reg(REG_CTR_Z,  {junk[CFG_DATA_W-1:CTR_W], cz});
    write_reg(REG_RADIUS, rad);
    write_reg(REG_FILL,   {junk[CFG_DATA_W-1:VAL_W], fill});
    settings_used++;
  endtask

  task automatic write_fill(input logic signed [VAL_W-1:0] fill);
    drain_paint();
    write_reg(REG_FILL, CFG_DATA_W'(fill) & CFG_DATA_W'({VAL_W{1'b1}}));
    settings_used++;
  endtask

  // Right after reset: centre at the origin, zero radius, fill of one.
  // Only the corner subsample of voxel 0,0,0 sits exactly on the centre.
  task automatic test_reset_values();
    send_voxel(6'd0, 6'd0, 6'd0, 18'sd12345);
    send_voxel(6'd1, 6'd0, 6'd0, -18'sd5);
  endtask

  // Sphere of radius three voxels centred inside voxel 10,10,10: full, partial
  // and zero coverage, with both painting and carving.
  task automatic test_sphere_coverage();
    set_shape(1'b0, 16'd8064, 16'd8064, 16'd8064, 34'd5308416, 18'sd65536);
    send_voxel(6'd10, 6'd10, 6'd10, 18'sd0);
    send_voxel(6'd13, 6'd10, 6'd10, 18'sd100);
    send_voxel(6'd63, 6'd63, 6'd63, 18'sd131071);
    send_voxel(6'd0, 6'd0, 6'd0, -18'sd131072);
    write_fill(18'sd0);
    send_voxel(6'd10, 6'd10, 6'd10, 18'sd131071);
    send_voxel(6'd12, 6'd10, 6'd10, -18'sd131072);
    send_voxel(6'd11, 6'd11, 6'd10, -18'sd1);
  endtask

  // The cylinder must ignore z entirely, even with the z centre far away.
  task automatic test_cylinder();
    set_shape(1'b1, 16'd8064, 16'd8064, 16'hFFFF, 34'd5308416, -18'sd65536);
    send_voxel(6'd10, 6'd10, 6'd63, 18'sd77);
    send_voxel(6'd10, 6'd10, 6'd0, 18'sh15555);
    send_voxel(6'd13, 6'd12, 6'd40, 18'sh2AAAA);
  endtask

  // Largest radius covers every voxel; fill at both 18-bit extremes and at
  // one; a zero radius cylinder at the origin covers one column.
  task automatic test_fill_extremes();
    set_shape(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, {RAD_W{1'b1}}, 18'sd131071);
    send_voxel(6'd63, 6'd0, 6'd63, -18'sd131072);
    send_voxel(6'd0, 6'd63, 6'd0, 18'sd5);
    write_fill(-18'sd131072);
    send_voxel(6'd63, 6'd63, 6'd63, 18'sd131071);
    write_fill(18'sd1);
    send_voxel(6'd21, 6'd42, 6'd21, -18'sd7);
    set_shape(1'b1, 16'd0, 16'd0, 16'd0, 34'd0, -18'sd131072);
    send_voxel(6'd0, 6'd0, 6'd37, -18'sd131072);
  endtask

  // Writes past the register list must leave every setting as it was.
  task automatic test_spare_indexes();
    drain_paint();
    write_reg(REG_SPARE_A, CFG_DATA_W'({$urandom, $urandom}));
    write_reg(REG_SPARE_B, CFG_DATA_W'({$urandom, $urandom}));
    send_voxel(6'd0, 6'd0, 6'd2, 18'sd1000);
    send_voxel(6'd1, 6'd1, 6'd1, -18'sd1000);
  endtask

  task automatic apply_random_settings();
    logic [CTR_W-1:0] c[3];
    logic [RAD_W-1:0] rad;
    logic signed [VAL_W-1:0] fill;
    int r256;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(15))
        0: c[i] = '0;
        1: c[i] = '1;
        default: c[i] = CTR_W'($urandom_range(0, 64 * VOXEL_SPAN - 1));
      endcase
    end
    case ($urandom_range(9))
      0: begin rad = '0; reach = 2; end
      1: begin rad = '1; reach = 63; end
      default: begin
        // Squared tripled radius with eight fraction bits, plus a fractional nudge.
        r256 = $urandom_range(128, 9000);
        rad = RAD_W'(r256 * r256 + $urandom_range(0, 2 * r256));
        reach = r256 / VOXEL_SPAN + 2;
      end
    endcase
    case ($urandom_range(9))
      6: fill = '0;
      7: fill = VAL_MAX;
      8: fill = VAL_MIN;
      9: fill = VAL_W'($urandom);
      default: fill = VAL_W'(int'($urandom_range(0, 131072)) - 65536);
    endcase
    set_shape(1'($urandom), c[0], c[1], c[2], rad, fill);
  endtask

  // Voxel index near the shape centre along one axis, kept inside the grid.
  function automatic logic [IDX_W-1:0] near_axis(input logic [CTR_W-1:0] centre);
    int v;
    v = int'(centre) / VOXEL_SPAN + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > GRID_SIZE - 1) v = GRID_SIZE - 1;
    return IDX_W'(v);
  endfunction

  task automatic send_random_voxel();
    logic [IDX_W-1:0] vx, vy, vz;
    logic signed [VAL_W-1:0] old;
    // Most voxels land around the surface where coverage is partial.
    if ($urandom_range(3) != 0) begin
      vx = near_axis(ctr_x);
      vy = near_axis(ctr_y);
      vz = near_axis(ctr_z);
    end else begin
      vx = IDX_W'($urandom);
      vy = IDX_W'($urandom);
      vz = IDX_W'($urandom);
    end
    case ($urandom_range(15))
      0: old = VAL_MAX;
      1: old = VAL_MIN;
      2: old = '0;
      3: old = '1;
      default: old = VAL_W'($urandom);
    endcase
    send_voxel(vx, vy, vz, old);
  endtask

  // One idling phase: three random register settings, with a full pause of
  // the sender partway through the second one.
  task automatic test_random_phase(input int send_idle, input int recv_stall,
                                   input int n_items);
    int per_set;
    per_set = n_items / 3;
    idle_pct = send_idle;
    stall_pct = recv_stall;
    for (int s = 0; s < 3; s++) begin
      apply_random_settings();
      for (int i = 0; i < per_set; i++) begin
        if (s == 1 && i == per_set / 2) drain_paint();
        send_random_voxel();
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    reach      = 2;
    cyl_mode   = 1'b0;
    ctr_x      = '0;
    ctr_y      = '0;
    ctr_z      = '0;
    rad_sq     = '0;
    fill_val   = FILL_RESET;
    mismatches = 0;
    voxels_sent = 0;
    voxels_checked = 0;
    voxels_touched = 0;
    settings_used = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_sphere_coverage();
    test_cylinder();
    test_fill_extremes();
    test_spare_indexes();
    test_random_phase(0, 0, 360);
    test_random_phase(81, 0, 360);
    test_random_phase(0, 81, 360);
    test_random_phase(13, 13, 360);

    drain_paint();
    // Anything that trails out after the last expected result is flagged.
    repeat (2 * NSTAGE) @(posedge clk);

    $display("Painted %0d voxels (%0d touched) under %0d register settings,",
             voxels_sent, voxels_touched, settings_used);
    $display("spheres and cylinders, with sender gaps and receiver stalls mixed in.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/ssf_pkg.sv
rtl/ssf_axis.sv
rtl/ssf_cover.sv
rtl/ssf_blend.sv
rtl/supersampled_sphere_cylinder_fill_core.sv
rtl/ssf_checker.sv
sim/tb.sv
